// ----- rtl/vpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vpd_pkg;

  // Fixed-point formats.
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int GAIN_FRAC_BITS  = 8;

  // Field widths.
  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 24;
  localparam int COUNT_W = 16;
  localparam int DRIVE_W = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_ANGLE    = 3'd0,
    REG_PROP_GAIN       = 3'd1,
    REG_DERIV_RATE_GAIN = 3'd2,
    REG_AGREE_THRESHOLD = 3'd3,
    REG_WATCHDOG_LIMIT  = 3'd4
  } cfg_reg_t;

  // Item kinds.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Register reset values.
  localparam logic [ANGLE_W-1:0] TARGET_RESET = ANGLE_W'(1 << ANGLE_FRAC_BITS);
  localparam logic [GAIN_W-1:0]  PROP_RESET   = GAIN_W'(36864);
  localparam logic [GAIN_W-1:0]  DERIV_RESET  = GAIN_W'(1738240);
  localparam logic [ANGLE_W-1:0] THRESH_RESET =
    ANGLE_W'(((5 << ANGLE_FRAC_BITS) + 50) / 100);
  localparam logic [COUNT_W-1:0] LIMIT_RESET  = COUNT_W'(2500);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Outcome of the sensor vote.
  typedef struct packed {
    logic [ANGLE_W-1:0] voted;
    logic               agree;
  } vote_t;

endpackage

`default_nettype wire

// ----- rtl/vpd_item_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface vpd_item_if;
  import vpd_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [ANGLE_W-1:0] sensor_a;
  logic [ANGLE_W-1:0] sensor_b;

  modport source (output valid, func, sensor_a, sensor_b, input ready);
  modport sink   (input valid, func, sensor_a, sensor_b, output ready);
endinterface

`default_nettype wire

// ----- rtl/vpd_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface vpd_result_if;
  import vpd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] drive;
  logic [ANGLE_W-1:0] voted_angle;
  logic               readings_match;
  logic [COUNT_W-1:0] disagree_total;
  logic               fault_flag;

  modport source (output valid, drive, voted_angle, readings_match, disagree_total,
                  fault_flag, input ready);
  modport sink   (input valid, drive, voted_angle, readings_match, disagree_total,
                  fault_flag, output ready);
endinterface

`default_nettype wire

// ----- rtl/vpd_vote.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vpd_vote (
  input  wire logic [vpd_pkg::ANGLE_W-1:0] sensor_a,
  input  wire logic [vpd_pkg::ANGLE_W-1:0] sensor_b,
  input  wire logic [vpd_pkg::ANGLE_W-1:0] threshold,
  output vpd_pkg::vote_t                   vote
);
  import vpd_pkg::*;

  logic [ANGLE_W:0] diff;
  logic [ANGLE_W:0] adiff;
  logic [ANGLE_W:0] sum;
  logic             agree;

  // Difference and magnitude, one bit wider so that no value wraps.
  assign diff  = {sensor_a[ANGLE_W-1], sensor_a} - {sensor_b[ANGLE_W-1], sensor_b};
  assign adiff = diff[ANGLE_W] ? (~diff + 1'b1) : diff;
  assign agree = adiff < {1'b0, threshold};

  // Floor average is the top bits of the sign-extended sum.
  assign sum = {sensor_a[ANGLE_W-1], sensor_a} + {sensor_b[ANGLE_W-1], sensor_b};

  assign vote.agree = agree;
  assign vote.voted = agree ? sum[ANGLE_W:1] : sensor_a;

endmodule

`default_nettype wire

// ----- rtl/vpd_law.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vpd_law (
  input  wire logic [vpd_pkg::ANGLE_W-1:0] voted,
  input  wire logic [vpd_pkg::ANGLE_W-1:0] last_voted,
  input  wire logic [vpd_pkg::ANGLE_W-1:0] target,
  input  wire logic [vpd_pkg::GAIN_W-1:0]  prop_gain,
  input  wire logic [vpd_pkg::GAIN_W-1:0]  deriv_gain,
  input  wire logic                        fault,
  output logic      [vpd_pkg::DRIVE_W-1:0] drive
);
  import vpd_pkg::*;

  localparam int ERR_W  = ANGLE_W + 1;
  localparam int PROD_W = GAIN_W + 1 + ERR_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SH_W   = ACC_W - GAIN_FRAC_BITS;

  logic signed [ERR_W-1:0]  p_err;
  logic signed [ERR_W-1:0]  d_err;
  logic signed [PROD_W-1:0] p_prod;
  logic signed [PROD_W-1:0] d_prod;
  logic signed [ACC_W-1:0]  acc;
  logic        [SH_W-1:0]   shifted;
  logic                     fits;

  // Error terms for the proportional and derivative paths.
  assign p_err = $signed({target[ANGLE_W-1], target}) - $signed({voted[ANGLE_W-1], voted});
  assign d_err = $signed({voted[ANGLE_W-1], voted})
               - $signed({last_voted[ANGLE_W-1], last_voted});

  // Two independent multiplies, then the difference.
  assign p_prod = $signed({1'b0, prop_gain}) * p_err;
  assign d_prod = $signed({1'b0, deriv_gain}) * d_err;
  assign acc    = $signed({p_prod[PROD_W-1], p_prod}) - $signed({d_prod[PROD_W-1], d_prod});

  // Dropping the gain fraction bits is a floor shift.
  assign shifted = acc[ACC_W-1:GAIN_FRAC_BITS];
  assign fits    = (shifted[SH_W-1:DRIVE_W-1] == '0) || (shifted[SH_W-1:DRIVE_W-1] == '1);

  // Saturate, and hold the motor off once the watchdog has tripped.
  always_comb begin
    priority if (fault) begin
      drive = '0;
    end else if (fits) begin
      drive = shifted[DRIVE_W-1:0];
    end else if (shifted[SH_W-1]) begin
      drive = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/voted_pd_servo_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A sample moves from the input register into the result register once that one
// is free. Throughput: one item per cycle unless a sample must wait for the result
// register; the vote and the PD law with its two multiplies sit between the input
// register and the result register in a single pass. Watchdog ticks produce no
// result and leave the input register without waiting for the result register.
// Reset (rst, synchronous, active high) restores the register defaults and clears
// the last angle, the disagreement count, the kick timer and the fault latch.
module voted_pd_servo_controller (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [vpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [vpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  vpd_item_if.sink                             items,
  vpd_result_if.source                         results
);
  import vpd_pkg::*;

  // Configuration registers.
  logic [ANGLE_W-1:0] target_angle;
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  deriv_rate_gain;
  logic [ANGLE_W-1:0] agree_threshold;
  logic [COUNT_W-1:0] watchdog_limit;

  // Controller state.
  logic [ANGLE_W-1:0] last_voted;
  logic [COUNT_W-1:0] disagree_counter;
  logic [COUNT_W-1:0] disagree_counter_next;
  logic [COUNT_W-1:0] kick_timer;
  logic [COUNT_W-1:0] kick_timer_next;
  logic               fault_latched;

  // Input register.
  logic               s1_valid;
  logic               s1_func;
  logic [ANGLE_W-1:0] s1_a;
  logic [ANGLE_W-1:0] s1_b;

  // Result register.
  logic               res_valid;
  logic [DRIVE_W-1:0] res_drive;
  logic [ANGLE_W-1:0] res_voted;
  logic               res_agree;
  logic [COUNT_W-1:0] res_total;
  logic               res_fault;

  logic               out_free;
  logic               s1_go;
  logic               s1_sample;
  vote_t              vote;
  logic [DRIVE_W-1:0] drive;

  // Handshake: ticks always leave the input register; samples need a free result slot.
  assign out_free    = !res_valid || results.ready;
  assign s1_sample   = s1_func == FUNC_SAMPLE;
  assign s1_go       = s1_valid && (!s1_sample || out_free);
  assign items.ready = !s1_valid || s1_go;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle    <= TARGET_RESET;
      prop_gain       <= PROP_RESET;
      deriv_rate_gain <= DERIV_RESET;
      agree_threshold <= THRESH_RESET;
      watchdog_limit  <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TARGET_ANGLE:    target_angle    <= cfg_data[ANGLE_W-1:0];
        REG_PROP_GAIN:       prop_gain       <= cfg_data[GAIN_W-1:0];
        REG_DERIV_RATE_GAIN: deriv_rate_gain <= cfg_data[GAIN_W-1:0];
        REG_AGREE_THRESHOLD: agree_threshold <= cfg_data[ANGLE_W-1:0];
        REG_WATCHDOG_LIMIT:  watchdog_limit  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register captures each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      s1_func <= items.func;
      s1_a    <= items.sensor_a;
      s1_b    <= items.sensor_b;
    end
  end

  // Sensor vote and control law.
  vpd_vote u_vote (
    .sensor_a  (s1_a),
    .sensor_b  (s1_b),
    .threshold (agree_threshold),
    .vote      (vote)
  );

  vpd_law u_law (
    .voted      (vote.voted),
    .last_voted (last_voted),
    .target     (target_angle),
    .prop_gain  (prop_gain),
    .deriv_gain (deriv_rate_gain),
    .fault      (fault_latched),
    .drive      (drive)
  );

  // Saturating counters.
  always_comb begin
    disagree_counter_next = disagree_counter;
    if (!vote.agree && disagree_counter != COUNT_MAX) begin
      disagree_counter_next = disagree_counter + 1'b1;
    end
    kick_timer_next = kick_timer;
    if (kick_timer != COUNT_MAX) begin
      kick_timer_next = kick_timer + 1'b1;
    end
  end

  // State advances as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_voted       <= '0;
      disagree_counter <= '0;
      kick_timer       <= '0;
      fault_latched    <= 1'b0;
    end else if (s1_go) begin
      if (s1_sample) begin
        last_voted       <= vote.voted;
        disagree_counter <= disagree_counter_next;
        kick_timer       <= '0;
      end else begin
        kick_timer <= kick_timer_next;
        if (kick_timer_next > watchdog_limit) begin
          fault_latched <= 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && s1_sample) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_sample) begin
      res_drive <= drive;
      res_voted <= vote.voted;
      res_agree <= vote.agree;
      res_total <= disagree_counter_next;
      res_fault <= fault_latched;
    end
  end

  assign results.valid          = res_valid;
  assign results.drive          = res_drive;
  assign results.voted_angle    = res_voted;
  assign results.readings_match = res_agree;
  assign results.disagree_total = res_total;
  assign results.fault_flag     = res_fault;

endmodule

`default_nettype wire

// ----- tb/sv/voted_pd_servo_controller_tb.sv -----
`timescale 1ns / 1ps

module voted_pd_servo_controller_tb;
  import vpd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 4;
  localparam int TICK_RUN_MAX = 4;
  localparam int LONG_RUN     = 100;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_INDEX = 3'd7;
  localparam longint DRIVE_HI = 2147483647;
  localparam longint DRIVE_LO = -DRIVE_HI - 1;

  typedef enum bit {STALL_NONE, STALL_PATTERN} stall_mode_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [ANGLE_W-1:0] voted_angle;
    logic               readings_match;
    logic [COUNT_W-1:0] disagree_total;
    logic               fault_flag;
  } servo_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  vpd_item_if   items_if();
  vpd_result_if results_if();

  voted_pd_servo_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .results   (results_if)
  );

  // Shadow copy of the configuration registers.
  logic signed [ANGLE_W-1:0] cfg_target     = TARGET_RESET;
  logic [GAIN_W-1:0]         cfg_prop_gain  = PROP_RESET;
  logic [GAIN_W-1:0]         cfg_deriv_gain = DERIV_RESET;
  logic [ANGLE_W-1:0]        cfg_threshold  = THRESH_RESET;
  logic [COUNT_W-1:0]        cfg_wd_limit   = LIMIT_RESET;

  // Shadow copy of the controller state.
  logic signed [ANGLE_W-1:0] last_voted     = '0;
  logic [COUNT_W-1:0]        disagree_count = '0;
  logic [COUNT_W-1:0]        kick_count     = '0;
  logic                      fault_seen     = 1'b0;

  servo_result_t pending_drive[$];

  int mismatches      = 0;
  int results_checked = 0;
  int samples_sent    = 0;
  int ticks_sent      = 0;
  int register_writes = 0;

  stall_mode_t stall_mode    = STALL_NONE;
  bit          sender_bursty = 1'b0;
  int          burst_left    = 1;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit in case the block hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: ready follows a rotating pattern that is reloaded now and then.
  logic [15:0] stall_pattern = 16'hFFFF;
  int          reload_count  = 0;
  always @(negedge clk) begin
    if (stall_mode == STALL_NONE) begin
      results_if.ready <= 1'b1;
    end else begin
      if (reload_count == 0) begin
        stall_pattern = 16'($urandom) | 16'h0001;
        reload_count  = $urandom_range(32, 128);
      end
      reload_count--;
      results_if.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Compare every accepted result with the oldest predicted one.
  always @(posedge clk) begin
    servo_result_t want;
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      if (pending_drive.size() == 0) begin
        mismatches++;
        $error("result arrived with no pending request");
      end else begin
        want = pending_drive.pop_front();
        results_checked++;
        check_field("drive", want.drive, results_if.drive);
        check_field("voted_angle", want.voted_angle, results_if.voted_angle);
        check_field("readings_match", want.readings_match, results_if.readings_match);
        check_field("disagree_total", want.disagree_total, results_if.disagree_total);
        check_field("fault_flag", want.fault_flag, results_if.fault_flag);
      end
    end
  end

  // Vote between the two readings and apply the PD law; updates the shadow state.
  function automatic servo_result_t predict_drive(logic [ANGLE_W-1:0] a_raw,
                                                  logic [ANGLE_W-1:0] b_raw);
    logic signed [ANGLE_W:0]   a, b, diff, sum;
    logic [ANGLE_W:0]          mag;
    logic                      agree;
    logic signed [ANGLE_W-1:0] voted;
    longint                    acc, drv;
    servo_result_t             r;
    a     = $signed(a_raw);
    b     = $signed(b_raw);
    diff  = a - b;
    mag   = (diff < 0) ? -diff : diff;
    agree = mag < {1'b0, cfg_threshold};
    sum   = a + b;
    if (agree) begin
      // Dropping the low bit of the sum is a floor halving.
      voted = sum[ANGLE_W:1];
    end else begin
      voted = a_raw;
      if (disagree_count != COUNT_MAX)
        disagree_count++;
    end
    acc = longint'(cfg_prop_gain) * (longint'(cfg_target) - longint'(voted))
        - longint'(cfg_deriv_gain) * (longint'(voted) - longint'(last_voted));
    drv = acc >>> GAIN_FRAC_BITS;
    if (drv > DRIVE_HI)
      drv = DRIVE_HI;
    if (drv < DRIVE_LO)
      drv = DRIVE_LO;
    if (fault_seen)
      drv = 0;
    last_voted       = voted;
    r.drive          = drv[DRIVE_W-1:0];
    r.voted_angle    = voted;
    r.readings_match = agree;
    r.disagree_total = disagree_count;
    r.fault_flag     = fault_seen;
    return r;
  endfunction

  // A tick moves the kick timer on and may latch the fault.
  function automatic void advance_watchdog();
    if (kick_count != COUNT_MAX)
      kick_count++;
    if (kick_count > cfg_wd_limit)
      fault_seen = 1'b1;
  endfunction

  // Send one request; called at a falling edge and returns at a falling edge.
  task automatic send_request(input logic kind, input logic [ANGLE_W-1:0] a,
                              input logic [ANGLE_W-1:0] b);
    items_if.valid    <= 1'b1;
    items_if.func     <= kind;
    items_if.sensor_a <= a;
    items_if.sensor_b <= b;
    @(posedge clk);
    while (items_if.ready !== 1'b1) @(posedge clk);
    if (kind == FUNC_TICK) begin
      advance_watchdog();
      ticks_sent++;
    end else begin
      kick_count = '0;
      pending_drive.push_back(predict_drive(a, b));
      samples_sent++;
    end
    @(negedge clk);
    if (sender_bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        items_if.valid    <= 1'b0;
        items_if.func     <= 1'($urandom);
        items_if.sensor_a <= 16'($urandom);
        items_if.sensor_b <= 16'($urandom);
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic send_tick();
    send_request(FUNC_TICK, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_sample(input logic [ANGLE_W-1:0] a, input logic [ANGLE_W-1:0] b);
    send_request(FUNC_SAMPLE, a, b);
  endtask

  // Wait until all results are in and the pipeline has emptied.
  task automatic wait_idle();
    items_if.valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_TARGET_ANGLE:    cfg_target     = value[ANGLE_W-1:0];
      REG_PROP_GAIN:       cfg_prop_gain  = value;
      REG_DERIV_RATE_GAIN: cfg_deriv_gain = value;
      REG_AGREE_THRESHOLD: cfg_threshold  = value[ANGLE_W-1:0];
      REG_WATCHDOG_LIMIT:  cfg_wd_limit   = value[COUNT_W-1:0];
      default: ;
    endcase
    register_writes++;
    @(negedge clk);
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // Second reading: often close to the first, sometimes right at the threshold.
  function automatic logic [ANGLE_W-1:0] partner_angle(logic [ANGLE_W-1:0] a);
    case ($urandom_range(0, 5))
      0:       return a + cfg_threshold;
      1:       return a - cfg_threshold + 16'd1;
      2:       return a + 16'($urandom_range(0, 64)) - 16'd32;
      3:       return a;
      4:       return random_angle();
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 24'($urandom_range(0, 65535));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic randomize_settings();
    logic [ANGLE_W-1:0] target, thresh;
    logic [COUNT_W-1:0] limit;
    case ($urandom_range(0, 3))
      0:       target = 16'h7FFF;
      1:       target = 16'h8000;
      default: target = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       thresh = '0;
      1:       thresh = '1;
      2:       thresh = 16'($urandom_range(1, 600));
      default: thresh = 16'($urandom);
    endcase
    // Keep the limit above the longest tick run so the fault stays clear.
    limit = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
            16'($urandom_range(TICK_RUN_MAX + 4, 65535));
    write_register(REG_TARGET_ANGLE, CFG_DATA_W'(target));
    write_register(REG_PROP_GAIN, random_gain());
    write_register(REG_DERIV_RATE_GAIN, random_gain());
    write_register(REG_AGREE_THRESHOLD, CFG_DATA_W'(thresh));
    write_register(REG_WATCHDOG_LIMIT, CFG_DATA_W'(limit));
  endtask

  // Samples with random content, with short runs of ticks between them.
  task automatic run_random_traffic(input int count);
    logic [ANGLE_W-1:0] a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, TICK_RUN_MAX)) send_tick();
      a = random_angle();
      send_sample(a, partner_angle(a));
    end
  endtask

  // Reset settings: extremes of the readings, rounding of the average, and
  // differences right at the agreement threshold.
  task automatic test_directed_votes();
    sender_bursty = 1'b1;
    stall_mode    = STALL_PATTERN;
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0001, 16'h0002);
    send_sample(16'hFFFF, 16'hFFFE);
    send_sample(16'd205, 16'd0);
    send_sample(16'd204, 16'd0);
    send_sample(16'd0, 16'd205);
    send_sample(16'hFF34, 16'd0);
    send_tick();
    send_tick();
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
    send_sample(16'h1000, 16'h1001);
  endtask

  // Largest and zero gains, both threshold extremes, and an unused index.
  task automatic test_gain_extremes();
    wait_idle();
    write_register(REG_TARGET_ANGLE, CFG_DATA_W'(16'h7FFF));
    write_register(REG_PROP_GAIN, '1);
    write_register(REG_DERIV_RATE_GAIN, '1);
    write_register(REG_AGREE_THRESHOLD, CFG_DATA_W'(16'hFFFF));
    write_register(REG_WATCHDOG_LIMIT, CFG_DATA_W'(16'hFFFF));
    write_register(REG_UNUSED_INDEX, 24'($urandom));
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    wait_idle();
    write_register(REG_TARGET_ANGLE, CFG_DATA_W'(16'h8000));
    write_register(REG_AGREE_THRESHOLD, '0);
    send_sample(16'h1234, 16'h1234);
    send_sample(16'h7FFF, 16'h7FFF);
    wait_idle();
    write_register(REG_PROP_GAIN, '0);
    write_register(REG_DERIV_RATE_GAIN, '0);
    send_sample(16'h8000, 16'h7FFF);
  endtask

  // Several random settings, each followed by random traffic.
  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      randomize_settings();
      stall_mode    = ($urandom_range(0, 2) == 0) ? STALL_NONE : STALL_PATTERN;
      sender_bursty = (p != 2);
      run_random_traffic(140);
    end
  endtask

  // With the largest limit a long run of ticks never trips the watchdog.
  task automatic test_long_tick_run();
    wait_idle();
    write_register(REG_WATCHDOG_LIMIT, CFG_DATA_W'(16'hFFFF));
    stall_mode    = STALL_NONE;
    sender_bursty = 1'b0;
    send_sample(16'h0100, 16'h0100);
    repeat (LONG_RUN) send_tick();
    send_sample(16'h0200, 16'h0210);
  endtask

  // A zero threshold never agrees, so every sample adds to the disagreement count.
  task automatic test_constant_disagreement();
    logic [ANGLE_W-1:0] a;
    wait_idle();
    write_register(REG_AGREE_THRESHOLD, '0);
    write_register(REG_PROP_GAIN, random_gain());
    write_register(REG_DERIV_RATE_GAIN, random_gain());
    stall_mode    = STALL_NONE;
    sender_bursty = 1'b0;
    repeat (LONG_RUN) begin
      a = random_angle();
      send_sample(a, partner_angle(a));
    end
  endtask

  // Watchdog boundary at limits of one and five, then the fault latches for good.
  task automatic test_watchdog_fault();
    wait_idle();
    write_register(REG_AGREE_THRESHOLD, CFG_DATA_W'(THRESH_RESET));
    write_register(REG_PROP_GAIN, CFG_DATA_W'(PROP_RESET));
    write_register(REG_DERIV_RATE_GAIN, CFG_DATA_W'(DERIV_RESET));
    write_register(REG_WATCHDOG_LIMIT, CFG_DATA_W'(16'd1));
    stall_mode    = STALL_PATTERN;
    sender_bursty = 1'b1;
    send_sample(16'h0800, 16'h0810);
    send_tick();
    send_sample(16'h0900, 16'h0900);
    wait_idle();
    write_register(REG_WATCHDOG_LIMIT, CFG_DATA_W'(16'd5));
    send_sample(16'h0A00, 16'h0A00);
    repeat (5) send_tick();
    send_sample(16'h0B00, 16'h0B00);
    repeat (6) send_tick();
    send_sample(16'h0C00, 16'h0C00);
    send_sample(16'h0C00, 16'h4000);
    run_random_traffic(40);
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    items_if.valid      = 1'b0;
    items_if.func       = FUNC_SAMPLE;
    items_if.sensor_a   = '0;
    items_if.sensor_b   = '0;
    results_if.ready    = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_directed_votes();
    test_gain_extremes();
    test_random_settings();
    test_long_tick_run();
    test_constant_disagreement();
    test_watchdog_fault();
    wait_idle();

    $display("Sent %0d sensor samples and %0d watchdog ticks across %0d register writes.",
             samples_sent, ticks_sent, register_writes);
    $display("Compared %0d results; %0d mismatches found.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/vpd_pkg.sv
rtl/vpd_item_if.sv
rtl/vpd_result_if.sv
rtl/vpd_vote.sv
rtl/vpd_law.sv
rtl/voted_pd_servo_controller.sv
tb/sv/voted_pd_servo_controller_tb.sv
